>>> sv/hnvu_pkg.sv
// Shared types, widths and constants for the HMM node Viterbi update unit.
// Used by the channel interfaces and the top level; depends on nothing.

package hnvu_pkg;

   localparam int LIKE_W = 32;
   localparam int DUR_W = 16;
   localparam int OP_W = 2;
   localparam int ADDR_W = 9;
   localparam int SLOT_W = 3;
   localparam int PHONE_W = ADDR_W - SLOT_W;
   localparam int PHONE_SPAN = 2 ** PHONE_W;

   // Slots 0 to 6 of a phone are read by a node update; slot 7 is never read.
   localparam int READ_SLOTS = 7;

   localparam int PHONE_COUNT_DEF = 64;
   localparam int DURATION_BITS_DEF = 16;

   localparam logic signed [LIKE_W-1:0] NEG_INF = {1'b1, {(LIKE_W-1){1'b0}}};
   localparam logic signed [LIKE_W-1:0] POS_MAX = {1'b0, {(LIKE_W-1){1'b1}}};

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_FRAME  = 2'd2
   } op_type;

   // Arc slots within one phone's table row.
   localparam int ARC_S0_S0 = 0;
   localparam int ARC_S0_S1 = 1;
   localparam int ARC_S0_S2 = 2;
   localparam int ARC_S1_S1 = 3;
   localparam int ARC_S1_S2 = 4;
   localparam int ARC_S2_S2 = 5;
   localparam int ARC_SELF0 = 6;

endpackage

>>> sv/hnvu_chan_if.sv
// Valid/ready channel interfaces for node update requests and results.
// Depends on hnvu_pkg for field widths.

interface hnvu_req_if;
   import hnvu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [ADDR_W-1:0]        table_address;
   logic signed [LIKE_W-1:0] score_value;
   logic signed [LIKE_W-1:0] state_like0;
   logic signed [LIKE_W-1:0] state_like1;
   logic signed [LIKE_W-1:0] state_like2;
   logic [DUR_W-1:0]         state_dur0;
   logic [DUR_W-1:0]         state_dur1;
   logic [DUR_W-1:0]         state_dur2;
   logic signed [LIKE_W-1:0] entry_like;
   logic [DUR_W-1:0]         entry_duration;
   logic signed [LIKE_W-1:0] entry_transition;

   modport source (
      output valid, op, table_address, score_value, state_like0, state_like1,
             state_like2, state_dur0, state_dur1, state_dur2, entry_like,
             entry_duration, entry_transition,
      input  ready
   );

   modport sink (
      input  valid, op, table_address, score_value, state_like0, state_like1,
             state_like2, state_dur0, state_dur1, state_dur2, entry_like,
             entry_duration, entry_transition,
      output ready
   );
endinterface

interface hnvu_rsp_if;
   import hnvu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [LIKE_W-1:0] new_like0;
   logic signed [LIKE_W-1:0] new_like1;
   logic signed [LIKE_W-1:0] new_like2;
   logic [DUR_W-1:0]         new_dur0;
   logic [DUR_W-1:0]         new_dur1;
   logic [DUR_W-1:0]         new_dur2;
   logic signed [LIKE_W-1:0] frame_max;

   modport source (
      output valid, new_like0, new_like1, new_like2, new_dur0, new_dur1, new_dur2,
             frame_max,
      input  ready
   );

   modport sink (
      input  valid, new_like0, new_like1, new_like2, new_dur0, new_dur1, new_dur2,
             frame_max,
      output ready
   );
endinterface

>>> sv/hmm_node_viterbi_update_unit.sv
// Top level of the HMM node Viterbi update unit: arc score table, add-compare-select
// pipeline and running frame maximum. Depends on hnvu_pkg and hnvu_chan_if.
//
//   channel   direction  handshake           carries
//   req_ch    in         valid/ready         op, table address, load score, node state
//   rsp_ch    out        valid/ready         new scores, new durations, frame maximum
//
// One item is accepted per cycle when the pipeline is not backed up. A node update
// reads its phone's table row at the accept edge, and its result is built up
// one register per step: row read, candidate sums, selection, local maximum,
// frame maximum.
// Loads complete at the accept edge; a start-of-frame item flows down the pipeline
// and clears the frame maximum in order with the updates around it.
// A stalled result stage backs up the stages behind it; stages with a bubble keep
// taking items. Reset clears the pipeline and sets the frame maximum to minus infinity.

module hmm_node_viterbi_update_unit #(
   parameter int PHONE_COUNT = hnvu_pkg::PHONE_COUNT_DEF,
   parameter int DURATION_BITS = hnvu_pkg::DURATION_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   hnvu_req_if.sink   req_ch,
   hnvu_rsp_if.source rsp_ch
);
   import hnvu_pkg::*;

   // Phones beyond what the address can name never need a row.
   localparam int ROWS = (PHONE_COUNT < PHONE_SPAN) ? PHONE_COUNT : PHONE_SPAN;
   localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [PHONE_W:0] PHONE_LIMIT = (PHONE_W + 1)'(ROWS);
   localparam bit DUR_SAT = (DURATION_BITS <= DUR_W);
   localparam logic [DUR_W-1:0] DUR_MASK =
      (DURATION_BITS >= DUR_W) ? {DUR_W{1'b1}} : DUR_W'((64'd1 << DURATION_BITS) - 64'd1);
   localparam logic signed [LIKE_W+1:0] SUM_MAX = (LIKE_W + 2)'(POS_MAX);
   localparam logic signed [LIKE_W+1:0] SUM_MIN = (LIKE_W + 2)'(NEG_INF);

   typedef logic signed [LIKE_W-1:0] like_type;
   typedef logic [DUR_W-1:0] dur_type;

   function automatic like_type sat_add(input like_type a, input like_type b,
                                        input like_type c);
      logic signed [LIKE_W+1:0] sum;
      like_type result;
      sum = (LIKE_W + 2)'(a) + (LIKE_W + 2)'(b) + (LIKE_W + 2)'(c);
      if (a == NEG_INF || b == NEG_INF || c == NEG_INF) begin
         result = NEG_INF;
      end else if (sum > SUM_MAX) begin
         result = POS_MAX;
      end else if (sum < SUM_MIN) begin
         result = NEG_INF;
      end else begin
         result = sum[LIKE_W-1:0];
      end
      return result;
   endfunction

   // The duration is already masked; it saturates only when the duration
   // width does not exceed the field, otherwise it wraps in the field.
   function automatic dur_type dur_inc(input dur_type d);
      dur_type result;
      if (DUR_SAT && d == DUR_MASK) begin
         result = d;
      end else begin
         result = d + dur_type'(1);
      end
      return result;
   endfunction

   // Pipeline enables: a stage moves when it is empty or its successor moves.
   logic s1_en, s2_en, s3_en, s4_en, s5_en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_frame_ff, s2_frame_ff, s3_frame_ff, s4_frame_ff;

   assign s5_en = !rsp_valid_ff || rsp_ch.ready;
   assign s4_en = !s4_valid_ff || s5_en;
   assign s3_en = !s3_valid_ff || s4_en;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_ch.ready = s1_en;

   // Accept and table access
   logic req_fire;
   logic [PHONE_W-1:0] phone;
   logic [SLOT_W-1:0] slot;
   logic phone_in_range;
   logic [ROW_BITS-1:0] row_index;
   logic s1_valid_in;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign phone = req_ch.table_address[ADDR_W-1:SLOT_W];
   assign slot = req_ch.table_address[SLOT_W-1:0];
   assign phone_in_range = {1'b0, phone} < PHONE_LIMIT;
   assign row_index = phone_in_range ? phone[ROW_BITS-1:0] : '0;
   assign s1_valid_in = req_fire && (req_ch.op == OP_UPDATE || req_ch.op == OP_FRAME);

   like_type table_mem [ROWS][READ_SLOTS];
   like_type s1_row_ff [READ_SLOTS];

   always_ff @(posedge clock) begin
      if (req_fire && req_ch.op == OP_LOAD && phone_in_range &&
          slot < SLOT_W'(READ_SLOTS)) begin
         table_mem[row_index][slot] <= req_ch.score_value;
      end
      if (s1_en) begin
         for (int s = 0; s < READ_SLOTS; s++) begin
            s1_row_ff[s] <= table_mem[row_index][s];
         end
      end
   end

   // Stage 1: node fields beside the table row.
   logic s1_in_range_ff;
   like_type s1_like_ff [3];
   dur_type s1_dur_ff [3];
   like_type s1_entry_like_ff, s1_entry_trans_ff;
   dur_type s1_entry_dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_frame_ff <= (req_ch.op == OP_FRAME);
         s1_in_range_ff <= phone_in_range;
         s1_like_ff[0] <= req_ch.state_like0;
         s1_like_ff[1] <= req_ch.state_like1;
         s1_like_ff[2] <= req_ch.state_like2;
         s1_dur_ff[0] <= req_ch.state_dur0 & DUR_MASK;
         s1_dur_ff[1] <= req_ch.state_dur1 & DUR_MASK;
         s1_dur_ff[2] <= req_ch.state_dur2 & DUR_MASK;
         s1_entry_like_ff <= req_ch.entry_like;
         s1_entry_trans_ff <= req_ch.entry_transition;
         s1_entry_dur_ff <= req_ch.entry_duration & DUR_MASK;
      end
   end

   // Stage 2: saturating candidate sums and incremented durations.
   like_type arc [READ_SLOTS];

   always_comb begin
      for (int s = 0; s < READ_SLOTS; s++) begin
         arc[s] = s1_in_range_ff ? s1_row_ff[s] : NEG_INF;
      end
   end

   like_type s2_c01_ff, s2_c00_ff, s2_c11_ff, s2_c10_ff, s2_c22_ff, s2_c21_ff, s2_c20_ff;
   dur_type s2_dur_ff [3];
   dur_type s2_inc_ff [3];
   dur_type s2_entry_inc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_frame_ff <= s1_frame_ff;
         s2_c01_ff <= sat_add(s1_entry_like_ff, s1_entry_trans_ff, arc[ARC_S0_S0]);
         s2_c00_ff <= sat_add(s1_like_ff[0], arc[ARC_SELF0], arc[ARC_S0_S0]);
         s2_c11_ff <= sat_add(s1_like_ff[0], arc[ARC_S0_S1], '0);
         s2_c10_ff <= sat_add(s1_like_ff[1], arc[ARC_S1_S1], '0);
         s2_c22_ff <= sat_add(s1_like_ff[0], arc[ARC_S0_S2], '0);
         s2_c21_ff <= sat_add(s1_like_ff[1], arc[ARC_S1_S2], '0);
         s2_c20_ff <= sat_add(s1_like_ff[2], arc[ARC_S2_S2], '0);
         for (int k = 0; k < 3; k++) begin
            s2_dur_ff[k] <= s1_dur_ff[k];
            s2_inc_ff[k] <= dur_inc(s1_dur_ff[k]);
         end
         s2_entry_inc_ff <= dur_inc(s1_entry_dur_ff);
      end
   end

   // Stage 3: compare and select; ties keep the staying path.
   like_type n0_in, n1_in, n2_in;
   dur_type nd0_in, nd1_in, nd2_in;

   always_comb begin
      if (s2_c01_ff > s2_c00_ff) begin
         n0_in = s2_c01_ff;
         nd0_in = s2_entry_inc_ff;
      end else if (s2_c00_ff != NEG_INF) begin
         n0_in = s2_c00_ff;
         nd0_in = s2_inc_ff[0];
      end else begin
         n0_in = NEG_INF;
         nd0_in = s2_dur_ff[0];
      end

      if (s2_c11_ff > s2_c10_ff) begin
         n1_in = s2_c11_ff;
         nd1_in = s2_inc_ff[0];
      end else if (s2_c10_ff != NEG_INF) begin
         n1_in = s2_c10_ff;
         nd1_in = s2_inc_ff[1];
      end else begin
         n1_in = NEG_INF;
         nd1_in = s2_dur_ff[1];
      end

      if (s2_c22_ff > s2_c21_ff && s2_c22_ff > s2_c20_ff) begin
         n2_in = s2_c22_ff;
         nd2_in = s2_inc_ff[0];
      end else if (s2_c22_ff <= s2_c21_ff && s2_c21_ff > s2_c20_ff) begin
         n2_in = s2_c21_ff;
         nd2_in = s2_inc_ff[1];
      end else if (s2_c20_ff != NEG_INF) begin
         n2_in = s2_c20_ff;
         nd2_in = s2_inc_ff[2];
      end else begin
         n2_in = NEG_INF;
         nd2_in = s2_dur_ff[2];
      end
   end

   like_type s3_n_ff [3];
   dur_type s3_nd_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_frame_ff <= s2_frame_ff;
         s3_n_ff[0] <= n0_in;
         s3_n_ff[1] <= n1_in;
         s3_n_ff[2] <= n2_in;
         s3_nd_ff[0] <= nd0_in;
         s3_nd_ff[1] <= nd1_in;
         s3_nd_ff[2] <= nd2_in;
      end
   end

   // Stage 4: largest of the node's three new scores.
   like_type max01, local_max_in;

   assign max01 = (s3_n_ff[1] > s3_n_ff[0]) ? s3_n_ff[1] : s3_n_ff[0];
   assign local_max_in = (s3_n_ff[2] > max01) ? s3_n_ff[2] : max01;

   like_type s4_n_ff [3];
   dur_type s4_nd_ff [3];
   like_type s4_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_frame_ff <= s3_frame_ff;
         s4_max_ff <= local_max_in;
         for (int k = 0; k < 3; k++) begin
            s4_n_ff[k] <= s3_n_ff[k];
            s4_nd_ff[k] <= s3_nd_ff[k];
         end
      end
   end

   // Stage 5: running frame maximum and result register.
   like_type running_max_ff, running_max_in;
   like_type rsp_like_ff [3];
   dur_type rsp_dur_ff [3];
   like_type rsp_max_ff;

   always_comb begin
      if (s4_frame_ff) begin
         running_max_in = NEG_INF;
      end else if (s4_max_ff > running_max_ff) begin
         running_max_in = s4_max_ff;
      end else begin
         running_max_in = running_max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         running_max_ff <= NEG_INF;
      end else if (s5_en) begin
         rsp_valid_ff <= s4_valid_ff && !s4_frame_ff;
         if (s4_valid_ff) begin
            running_max_ff <= running_max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en && s4_valid_ff && !s4_frame_ff) begin
         rsp_max_ff <= running_max_in;
         for (int k = 0; k < 3; k++) begin
            rsp_like_ff[k] <= s4_n_ff[k];
            rsp_dur_ff[k] <= s4_nd_ff[k];
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.new_like0 = rsp_like_ff[0];
   assign rsp_ch.new_like1 = rsp_like_ff[1];
   assign rsp_ch.new_like2 = rsp_like_ff[2];
   assign rsp_ch.new_dur0 = rsp_dur_ff[0];
   assign rsp_ch.new_dur1 = rsp_dur_ff[1];
   assign rsp_ch.new_dur2 = rsp_dur_ff[2];
   assign rsp_ch.frame_max = rsp_max_ff;

endmodule
